// File: src/pisl_pkg.sv
`timescale 1ns / 1ps

package pisl_pkg;

    // Field and datapath widths
    localparam int NOISE_W  = 8;
    localparam int SP_W     = 10;
    localparam int GAIN_W   = 16;
    localparam int CNT_W    = 16;
    localparam int Q_W      = 32;
    localparam int ERR_W    = 34;
    localparam int A_W      = 35;
    localparam int B_W      = 18;
    localparam int PROD_W   = A_W + B_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 3 * Q_W;

    localparam int SETPOINT_INTERVAL_MS = 15000;

    // Plant and noise coefficients
    localparam logic signed [B_W-1:0] PLANT_DECAY = B_W'(63917);
    localparam logic signed [B_W-1:0] PLANT_GAIN  = B_W'(1618);
    localparam logic signed [B_W-1:0] NOISE_MUL   = B_W'(67109);
    localparam logic [GAIN_W:0]       ALPHA_ONE   = 17'h10000;

    // Round-half-up offsets and saturation limits
    localparam logic signed [SUM_W-1:0] HALF11 = SUM_W'(1024);
    localparam logic signed [SUM_W-1:0] HALF12 = SUM_W'(2048);
    localparam logic signed [SUM_W-1:0] HALF16 = SUM_W'(32768);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT_0  = 3'd0,
        REG_SETPOINT_1  = 3'd1,
        REG_SETPOINT_2  = 3'd2,
        REG_SETPOINT_3  = 3'd3,
        REG_PROP_GAIN   = 3'd4,
        REG_INTEG_GAIN  = 3'd5,
        REG_FILT_ALPHA  = 3'd6,
        REG_SAMPLE_INTV = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_NOISE,
        ST_MUL_SP,
        ST_MUL_DECAY,
        ST_SPEED,
        ST_MUL_FA,
        ST_MUL_FB,
        ST_FILT,
        ST_ERR,
        ST_MUL_KI,
        ST_MUL_KP,
        ST_CTRL,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_NOISE,
        MUL_SP,
        MUL_DECAY,
        MUL_FA,
        MUL_FB,
        MUL_KI,
        MUL_KP
    } mul_sel_t;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_NOISE,
        ALU_ADD,
        ALU_SPEED,
        ALU_LOAD,
        ALU_FILT,
        ALU_ERR,
        ALU_INTEG,
        ALU_CTRL
    } alu_op_t;

    typedef struct packed {
        mul_sel_t   mul_sel;
        alu_op_t    alu_op;
        logic       ld_noise;
        logic [1:0] sp_index;
    } cmd_t;

    typedef struct packed {
        logic [3:0][SP_W-1:0] setpoint;
        logic [GAIN_W-1:0]    prop_gain;
        logic [GAIN_W-1:0]    integ_gain_dt;
        logic [GAIN_W-1:0]    filter_alpha;
        logic [CNT_W-1:0]     sample_interval_ms;
    } cfg_t;

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[Q_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[Q_W-1:0];
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/pisl_ctrl.sv
`timescale 1ns / 1ps

module pisl_ctrl import pisl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CNT_W-1:0] sample_interval_ms,
    input  logic             out_free,
    output logic             out_load,
    output cmd_t             cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] smp_cnt_reg, smp_cnt_next;
    logic [CNT_W-1:0] spt_cnt_reg, spt_cnt_next;
    logic [1:0]       sp_idx_reg, sp_idx_next;

    logic             accept;
    logic             fire;
    logic             spt_wrap;
    logic [CNT_W:0]   smp_inc;
    logic [CNT_W:0]   spt_inc;
    logic [CNT_W-1:0] interval;

    assign accept = s_tvalid && s_tready;

    // Tick counters
    always_comb begin
        interval = (sample_interval_ms == '0) ? CNT_W'(1) : sample_interval_ms;
        smp_inc  = {1'b0, smp_cnt_reg} + (CNT_W+1)'(1);
        spt_inc  = {1'b0, spt_cnt_reg} + (CNT_W+1)'(1);
        fire     = smp_inc >= {1'b0, interval};
        spt_wrap = spt_inc >= (CNT_W+1)'(SETPOINT_INTERVAL_MS);

        smp_cnt_next = smp_cnt_reg;
        spt_cnt_next = spt_cnt_reg;
        sp_idx_next  = sp_idx_reg;
        if (accept) begin
            smp_cnt_next = fire ? '0 : smp_inc[CNT_W-1:0];
            if (spt_wrap) begin
                spt_cnt_next = '0;
                sp_idx_next  = sp_idx_reg + 2'd1;
            end else begin
                spt_cnt_next = spt_inc[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (accept && fire) state_next = ST_MUL_NOISE;
            ST_MUL_NOISE: state_next = ST_MUL_SP;
            ST_MUL_SP:    state_next = ST_MUL_DECAY;
            ST_MUL_DECAY: state_next = ST_SPEED;
            ST_SPEED:     state_next = ST_MUL_FA;
            ST_MUL_FA:    state_next = ST_MUL_FB;
            ST_MUL_FB:    state_next = ST_FILT;
            ST_FILT:      state_next = ST_ERR;
            ST_ERR:       state_next = ST_MUL_KI;
            ST_MUL_KI:    state_next = ST_MUL_KP;
            ST_MUL_KP:    state_next = ST_CTRL;
            ST_CTRL:      state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        out_load     = 1'b0;
        cmd.mul_sel  = MUL_NONE;
        cmd.alu_op   = ALU_NONE;
        cmd.ld_noise = 1'b0;
        cmd.sp_index = sp_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.ld_noise = s_tvalid && fire;
            end
            ST_MUL_NOISE: cmd.mul_sel = MUL_NOISE;
            ST_MUL_SP: begin
                cmd.mul_sel = MUL_SP;
                cmd.alu_op  = ALU_NOISE;
            end
            ST_MUL_DECAY: begin
                cmd.mul_sel = MUL_DECAY;
                cmd.alu_op  = ALU_ADD;
            end
            ST_SPEED:  cmd.alu_op = ALU_SPEED;
            ST_MUL_FA: cmd.mul_sel = MUL_FA;
            ST_MUL_FB: begin
                cmd.mul_sel = MUL_FB;
                cmd.alu_op  = ALU_LOAD;
            end
            ST_FILT:   cmd.alu_op = ALU_FILT;
            ST_ERR:    cmd.alu_op = ALU_ERR;
            ST_MUL_KI: cmd.mul_sel = MUL_KI;
            ST_MUL_KP: begin
                cmd.mul_sel = MUL_KP;
                cmd.alu_op  = ALU_INTEG;
            end
            ST_CTRL:   cmd.alu_op = ALU_CTRL;
            ST_DONE:   out_load = out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            smp_cnt_reg <= '0;
            spt_cnt_reg <= '0;
            sp_idx_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            smp_cnt_reg <= smp_cnt_next;
            spt_cnt_reg <= spt_cnt_next;
            sp_idx_reg  <= sp_idx_next;
        end
    end

endmodule

// File: src/pisl_datapath.sv
`timescale 1ns / 1ps

module pisl_datapath import pisl_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    input  cfg_t                      cfg,
    input  logic signed [NOISE_W-1:0] noise_in,
    output logic signed [Q_W-1:0]     speed_o,
    output logic signed [Q_W-1:0]     filtered_o,
    output logic signed [Q_W-1:0]     control_o
);

    logic signed [Q_W-1:0]     speed_reg, speed_next;
    logic signed [Q_W-1:0]     filtered_reg, filtered_next;
    logic signed [Q_W-1:0]     integral_reg, integral_next;
    logic signed [Q_W-1:0]     ctrl_reg, ctrl_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [NOISE_W-1:0] noise_reg;

    logic [SP_W-1:0]         sp;
    logic signed [A_W-1:0]   mul_a;
    logic signed [B_W-1:0]   mul_b;
    logic signed [SUM_W-1:0] prod_x;
    logic signed [SUM_W-1:0] integ_x;
    logic signed [SUM_W-1:0] rnd11, rnd12, rnd16;
    logic signed [SUM_W-1:0] filt_sum;
    logic [GAIN_W:0]         alpha_rest;

    assign sp         = cfg.setpoint[cmd.sp_index];
    assign alpha_rest = ALPHA_ONE - {1'b0, cfg.filter_alpha};

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_NOISE: begin
                mul_a = A_W'(noise_reg);
                mul_b = NOISE_MUL;
            end
            MUL_SP: begin
                mul_a = $signed({{(A_W-SP_W){1'b0}}, sp});
                mul_b = PLANT_GAIN;
            end
            MUL_DECAY: begin
                mul_a = A_W'(speed_reg);
                mul_b = PLANT_DECAY;
            end
            MUL_FA: begin
                mul_a = A_W'(speed_reg);
                mul_b = $signed({2'b00, cfg.filter_alpha});
            end
            MUL_FB: begin
                mul_a = A_W'(filtered_reg);
                mul_b = $signed({1'b0, alpha_rest});
            end
            MUL_KI: begin
                mul_a = A_W'(err_reg);
                mul_b = $signed({2'b00, cfg.integ_gain_dt});
            end
            MUL_KP: begin
                mul_a = A_W'(err_reg);
                mul_b = $signed({2'b00, cfg.prop_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb begin
        prod_x   = SUM_W'(prod_reg);
        integ_x  = SUM_W'(integral_reg);
        rnd11    = (prod_x + HALF11) >>> 11;
        rnd12    = (prod_x + HALF12) >>> 12;
        rnd16    = (prod_x + HALF16) >>> 16;
        filt_sum = (acc_reg + prod_x + HALF16) >>> 16;

        acc_next      = acc_reg;
        speed_next    = speed_reg;
        filtered_next = filtered_reg;
        integral_next = integral_reg;
        err_next      = err_reg;
        ctrl_next     = ctrl_reg;
        case (cmd.alu_op)
            ALU_NOISE: acc_next = rnd11;
            ALU_ADD:   acc_next = acc_reg + prod_x;
            ALU_SPEED: speed_next = sat32(acc_reg + rnd16);
            ALU_LOAD:  acc_next = prod_x;
            ALU_FILT:  filtered_next = sat32(filt_sum);
            ALU_ERR:   err_next = ERR_W'($signed({2'b00, sp, 16'h0000})) - ERR_W'(filtered_reg);
            ALU_INTEG: integral_next = sat32(integ_x + rnd16);
            ALU_CTRL:  ctrl_next = sat32(rnd12 + integ_x);
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg    <= '0;
            filtered_reg <= '0;
            integral_reg <= '0;
        end else begin
            speed_reg    <= speed_next;
            filtered_reg <= filtered_next;
            integral_reg <= integral_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        err_reg  <= err_next;
        ctrl_reg <= ctrl_next;
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        if (cmd.ld_noise) begin
            noise_reg <= noise_in;
        end
    end

    assign speed_o    = speed_reg;
    assign filtered_o = filtered_reg;
    assign control_o  = ctrl_reg;

endmodule

// File: src/pi_speed_loop_with_plant_model_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload (low bit up)                                   Handshake
// s_       in   tdata[7:0] noise_hundredths                            s_tvalid/s_tready
// m_       out  tdata plant_speed, filtered_speed, control_output      m_tvalid/m_tready
// cfg_     in   cfg_index register, cfg_data value                     cfg_valid/cfg_ready
//
// A tick that does not reach the sample interval only advances the counters.
// A sample tick runs eleven steps of the shared 35x18 multiplier
// and its accumulator, then a hand-off into the output register.
// The output register frees the datapath: new ticks are taken while a result waits.
// Reset (aresetn low, synchronous) clears counters and loop state and sets config registers to defaults.
// A stalled m_ side holds the block only when a second result is ready.

module pi_speed_loop_with_plant_model_unit import pisl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,    // [7:0] noise_hundredths
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,    // [31:0] plant_speed, [63:32] filtered_speed,
                                             // [95:64] control_output
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data
);

    cfg_t                  cfg_reg, cfg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]   out_data_reg;
    logic                  out_free;
    logic                  out_load;
    cmd_t                  cmd;
    logic signed [Q_W-1:0] speed, filtered, control;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_SETPOINT_0:  cfg_next.setpoint[0] = cfg_data[SP_W-1:0];
                REG_SETPOINT_1:  cfg_next.setpoint[1] = cfg_data[SP_W-1:0];
                REG_SETPOINT_2:  cfg_next.setpoint[2] = cfg_data[SP_W-1:0];
                REG_SETPOINT_3:  cfg_next.setpoint[3] = cfg_data[SP_W-1:0];
                REG_PROP_GAIN:   cfg_next.prop_gain = cfg_data;
                REG_INTEG_GAIN:  cfg_next.integ_gain_dt = cfg_data;
                REG_FILT_ALPHA:  cfg_next.filter_alpha = cfg_data;
                REG_SAMPLE_INTV: cfg_next.sample_interval_ms = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint[0]        <= SP_W'(100);
            cfg_reg.setpoint[1]        <= SP_W'(110);
            cfg_reg.setpoint[2]        <= SP_W'(100);
            cfg_reg.setpoint[3]        <= SP_W'(90);
            cfg_reg.prop_gain          <= GAIN_W'(22118);
            cfg_reg.integ_gain_dt      <= GAIN_W'(5898);
            cfg_reg.filter_alpha       <= GAIN_W'(3277);
            cfg_reg.sample_interval_ms <= CNT_W'(50);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pisl_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .sample_interval_ms (cfg_reg.sample_interval_ms),
        .out_free           (out_free),
        .out_load           (out_load),
        .cmd                (cmd)
    );

    pisl_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .noise_in   ($signed(s_tdata[NOISE_W-1:0])),
        .speed_o    (speed),
        .filtered_o (filtered),
        .control_o  (control)
    );

    // Output register: take a new result when empty or being drained
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {control, filtered, speed};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: src/pisl_checker.sv
`timescale 1ns / 1ps

module pisl_checker import pisl_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // A fresh result comes only out of a busy sample cycle
    a_rise_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a sample computation");

    // Input side only goes busy after taking a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input went busy without a transaction");

    // Nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pi_speed_loop_with_plant_model_unit pisl_checker u_pisl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/tb_pi_speed_loop_with_plant_model_unit.sv
`timescale 1ns / 1ps

module tb_pi_speed_loop_with_plant_model_unit;
    import pisl_pkg::*;

    // Mirror of the speed loop: plant, low-pass filter and PI controller in Q16.16
    class speed_loop_scoreboard;
        localparam longint DECAY_Q16 = 63917;
        localparam longint GAIN_Q16  = 1618;
        localparam longint NOISE_K   = 67109;

        logic [SP_W-1:0]   setpoint [4];
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain_dt;
        logic [GAIN_W-1:0] filter_alpha;
        logic [CNT_W-1:0]  sample_interval;

        longint      speed;
        longint      filtered;
        longint      integral;
        int unsigned sp_index;
        int unsigned sample_ticks;
        int unsigned setpoint_ticks;

        logic [M_DATA_W-1:0] expected_samples [$];
        int mismatches;

        function new();
            setpoint[0]     = 100;
            setpoint[1]     = 110;
            setpoint[2]     = 100;
            setpoint[3]     = 90;
            prop_gain       = 22118;
            integ_gain_dt   = 5898;
            filter_alpha    = 3277;
            sample_interval = 50;
            speed           = 0;
            filtered        = 0;
            integral        = 0;
            sp_index        = 0;
            sample_ticks    = 0;
            setpoint_ticks  = 0;
            mismatches      = 0;
        endfunction

        function longint round_half_up(longint v, int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        function longint clamp_q16(longint v);
            if (v > 64'sh7FFF_FFFF)
                return 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000)
                return -64'sh8000_0000;
            return v;
        endfunction

        function void apply_write(cfg_idx_t idx, logic [GAIN_W-1:0] val);
            case (idx)
                REG_SETPOINT_0, REG_SETPOINT_1, REG_SETPOINT_2, REG_SETPOINT_3: begin
                    setpoint[int'(idx) - int'(REG_SETPOINT_0)] = val[SP_W-1:0];
                end
                REG_PROP_GAIN:   prop_gain       = val;
                REG_INTEG_GAIN:  integ_gain_dt   = val;
                REG_FILT_ALPHA:  filter_alpha    = val;
                REG_SAMPLE_INTV: sample_interval = val;
                default: ;
            endcase
        endfunction

        function void predict_tick(logic [NOISE_W-1:0] noise);
            longint      noise_q;
            longint      sp;
            longint      err;
            longint      ctrl;
            int unsigned interval;

            setpoint_ticks++;
            if (setpoint_ticks >= SETPOINT_INTERVAL_MS) begin
                setpoint_ticks = 0;
                sp_index = (sp_index + 1) % 4;
            end

            interval = (sample_interval == 0) ? 1 : sample_interval;
            sample_ticks++;
            if (sample_ticks < interval)
                return;
            sample_ticks = 0;

            noise_q  = round_half_up(longint'($signed(noise)) * NOISE_K, 11);
            sp       = longint'(setpoint[sp_index]);
            speed    = clamp_q16(round_half_up(speed * DECAY_Q16, 16) + sp * GAIN_Q16 + noise_q);
            filtered = clamp_q16(round_half_up(longint'(filter_alpha) * speed
                           + (65536 - longint'(filter_alpha)) * filtered, 16));
            err      = sp * 65536 - filtered;
            integral = clamp_q16(integral + round_half_up(longint'(integ_gain_dt) * err, 16));
            ctrl     = clamp_q16(round_half_up(longint'(prop_gain) * err, 12) + integral);
            expected_samples.push_back({32'(ctrl), 32'(filtered), 32'(speed)});
        endfunction

        function void check_sample(logic [M_DATA_W-1:0] got);
            string               names [3] = '{"plant_speed", "filtered_speed", "control_output"};
            logic [M_DATA_W-1:0] want;

            if (expected_samples.size() == 0) begin
                $display("%0t: result with none expected, got %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_samples.pop_front();
            for (int k = 0; k < 3; k++) begin
                if (want[k*Q_W +: Q_W] !== got[k*Q_W +: Q_W]) begin
                    $display("%0t: %s mismatch, expected %h actual %h", $time, names[k],
                             want[k*Q_W +: Q_W], got[k*Q_W +: Q_W]);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [NOISE_W-1:0] NOISE_CORNERS [12] = '{
        8'h80, 8'h7F, 8'h9C, 8'h64, 8'h00, 8'hFF, 8'h01, 8'h55, 8'hAA, 8'hF0, 8'h0F, 8'hC0
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = REG_SETPOINT_0;
    logic [GAIN_W-1:0]    cfg_data  = '0;

    speed_loop_scoreboard sb = new();
    bit                   s_idle_en  = 1'b1;
    bit                   m_stall_en = 1'b0;
    int                   cycle_count = 0;

    always #(CLK_HALF) aclk = ~aclk;

    pi_speed_loop_with_plant_model_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge aclk) begin
        if (m_stall_en)
            m_tready <= ($urandom_range(99) >= 32);
        else
            m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_sample(m_tdata);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [NOISE_W-1:0] rand_noise();
        if ($urandom_range(4) == 0)
            return NOISE_W'($urandom);
        return NOISE_W'(int'($urandom_range(200)) - 100);
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Upper bits above the setpoint field are junk the block must drop
    function automatic logic [GAIN_W-1:0] rand_setpoint_word();
        logic [SP_W-1:0] sp;
        case ($urandom_range(5))
            0:       sp = '0;
            1:       sp = '1;
            default: sp = SP_W'($urandom);
        endcase
        return {(GAIN_W - SP_W)'($urandom_range(1) ? $urandom : 0), sp};
    endfunction

    function automatic logic [GAIN_W-1:0] rand_interval();
        case ($urandom_range(7))
            0:       return '0;
            1:       return GAIN_W'($urandom_range(7, 25));
            default: return GAIN_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic send_tick(input logic [NOISE_W-1:0] noise);
        while (s_idle_en && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= noise;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_tick(noise);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.apply_write(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the sender until every pending result is out and the datapath is quiet
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_all_setpoints(input logic [GAIN_W-1:0] val);
        write_reg(REG_SETPOINT_0, val);
        write_reg(REG_SETPOINT_1, val);
        write_reg(REG_SETPOINT_2, val);
        write_reg(REG_SETPOINT_3, val);
    endtask

    task automatic run_random_phase(input int n_items);
        drain_results();
        write_reg(REG_SETPOINT_0, rand_setpoint_word());
        write_reg(REG_SETPOINT_1, rand_setpoint_word());
        write_reg(REG_SETPOINT_2, rand_setpoint_word());
        write_reg(REG_SETPOINT_3, rand_setpoint_word());
        write_reg(REG_PROP_GAIN, rand_gain());
        write_reg(REG_INTEG_GAIN, rand_gain());
        write_reg(REG_FILT_ALPHA, rand_gain());
        write_reg(REG_SAMPLE_INTV, rand_interval());
        repeat (n_items) send_tick(rand_noise());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn    <= 1'b1;
        m_stall_en <= 1'b1;
        @(posedge aclk);

        // Reset settings: one update every 50 ticks
        repeat (50) send_tick(rand_noise());

        // Zero interval acts as one; push noise corners through
        drain_results();
        write_reg(REG_SAMPLE_INTV, '0);
        foreach (NOISE_CORNERS[k]) send_tick(NOISE_CORNERS[k]);

        // Interval dropped below the running count fires on the next tick
        drain_results();
        write_reg(REG_SAMPLE_INTV, 16'd8);
        repeat (5) send_tick(rand_noise());
        drain_results();
        write_reg(REG_SAMPLE_INTV, 16'd2);
        repeat (2) send_tick(rand_noise());

        // Drive integral and control into positive saturation
        drain_results();
        write_all_setpoints('1);
        write_reg(REG_PROP_GAIN, '1);
        write_reg(REG_INTEG_GAIN, '1);
        write_reg(REG_FILT_ALPHA, '1);
        write_reg(REG_SAMPLE_INTV, 16'd1);
        repeat (150) send_tick(rand_noise());

        // Freeze the filter high and drop the setpoint: negative saturation
        drain_results();
        write_reg(REG_FILT_ALPHA, '0);
        write_all_setpoints('0);
        repeat (150) send_tick(rand_noise());

        // No idling on either side
        drain_results();
        s_idle_en = 1'b0;
        m_stall_en <= 1'b0;
        run_random_phase($urandom_range(150, 200));
        m_stall_en <= 1'b1;

        s_idle_en = 1'b1;
        for (int ph = 0; ph < 5; ph++)
            run_random_phase($urandom_range(150, 200));

        drain_results();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/pisl_pkg.sv
src/pisl_ctrl.sv
src/pisl_datapath.sv
src/pi_speed_loop_with_plant_model_unit.sv
src/pisl_checker.sv
sim/tb_pi_speed_loop_with_plant_model_unit.sv
